// ----- hw/rtl/pcmt_pkg.sv -----
// ----------------------------------------------------------------------------
// pcmt_pkg
// Shared types and constants for the pixel colour-mode translator.
// ----------------------------------------------------------------------------
package pcmt_pkg;

	typedef logic [7:0] chan_t;

	typedef enum logic [1:0] {
		MODE_NORMAL   = 2'd0,
		MODE_ALPHA    = 2'd1,
		MODE_TWOCOLOR = 2'd2,
		MODE_RAMP     = 2'd3
	} mode_t;

	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_FORE = 2'd1;
	localparam logic [1:0] REG_BACK = 2'd2;

	localparam logic [23:0] FORE_RESET = 24'h000000;
	localparam logic [23:0] BACK_RESET = 24'hFFFFFF;

	// luma weights
	localparam logic [14:0] W_RED   = 15'd30;
	localparam logic [14:0] W_GREEN = 15'd59;
	localparam logic [14:0] W_BLUE  = 15'd11;
	localparam logic [14:0] WSUM_MAX = 15'd25500;

	// x/100 for x < 25600: (x * 20972) >> 21
	localparam logic [29:0] GRAY_RECIP = 30'd20972;
	localparam int unsigned GRAY_SHIFT = 21;

	// x/255 for x <= 65025: (x * 65794) >> 24
	localparam logic [32:0] DIV255_RECIP = 33'd65794;
	localparam int unsigned DIV255_SHIFT = 24;

	localparam logic [7:0]  DARK_LIMIT    = 8'd35;
	localparam logic [7:0]  LIGHT_LIMIT   = 8'd221;
	localparam logic [17:0] NEUTRAL_LIMIT = 18'd20;

endpackage

// ----- hw/rtl/pcmt_ramp.sv -----
// ----------------------------------------------------------------------------
// pcmt_ramp
// One channel of the gray ramp: fc + (bc - fc) * gray / 255, truncated
// toward zero. Product at s3, quotient at s4, sum combinational after s4.
// ----------------------------------------------------------------------------
module pcmt_ramp import pcmt_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  chan_t gray_s2,
	input  chan_t fc,
	input  chan_t bc,
	output chan_t ramp
);

	logic signed [8:0]  span;
	logic signed [17:0] prod_s3;
	logic [16:0]        mag_full;
	logic [32:0]        qprod;
	chan_t              q_s4;
	logic               neg_s4;

	assign span = $signed({1'b0, bc}) - $signed({1'b0, fc});

	assign mag_full = prod_s3[17] ? 17'(-prod_s3) : prod_s3[16:0];
	assign qprod    = 33'(mag_full[15:0]) * DIV255_RECIP;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= 18'(span) * $signed({10'd0, gray_s2});
			q_s4    <= qprod[DIV255_SHIFT +: 8];
			neg_s4  <= prod_s3[17];
		end
	end

	assign ramp = neg_s4 ? chan_t'(fc - q_s4) : chan_t'(fc + q_s4);

endmodule

// ----- hw/rtl/pixel_color_mode_translate.sv -----
// ----------------------------------------------------------------------------
// pixel_color_mode_translate
// ARGB pixel colour-mode translation: pass-through, two-colour substitution
// or gray ramp between foreground and background colours.
// ----------------------------------------------------------------------------
// A fully pipelined stream block: one pixel is accepted every clock while the
// output is not stalled, and each pixel passes through the registered stages
// luma sum, divide by 100, squares and ramp products, divide by 255 and
// output select. Backpressure on the master side stalls every stage together;
// while a result waits in the output register, s_axis_tready follows
// m_axis_tready in the same cycle, so a new pixel enters as the waiting one
// leaves. Write the mode and colour registers only while no pixel is in flight.
// ----------------------------------------------------------------------------
module pixel_color_mode_translate import pcmt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // pixel_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // pixel_out
);

	mode_t       mode_q;
	logic [23:0] fore_q;
	logic [23:0] back_q;

	logic        en;
	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [31:0] px_s1, px_s2, px_s3, px_s4, px_s5;
	logic [14:0] ws_s1;
	chan_t       gray_s2, gray_s3;
	logic [17:0] dist_s3;
	logic        dark_s4, light_s4;

	logic [29:0]        gprod;
	logic signed [8:0]  dr, dg, db;
	logic [17:0]        sq_dist;
	chan_t              ramp_r, ramp_g, ramp_b;
	logic [31:0]        px_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			fore_q <= FORE_RESET;
			back_q <= BACK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= mode_t'(cfg_data[1:0]);
				REG_FORE: fore_q <= cfg_data;
				REG_BACK: back_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	assign en            = !vld_s5 || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	assign gprod = 30'(ws_s1) * GRAY_RECIP;

	assign dr = $signed({1'b0, px_s2[23:16]}) - $signed({1'b0, gray_s2});
	assign dg = $signed({1'b0, px_s2[15:8]})  - $signed({1'b0, gray_s2});
	assign db = $signed({1'b0, px_s2[7:0]})   - $signed({1'b0, gray_s2});
	assign sq_dist = unsigned'(18'(dr) * 18'(dr) + 18'(dg) * 18'(dg)
		+ 18'(db) * 18'(db));

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1    <= s_axis_tdata;
			ws_s1    <= 15'(s_axis_tdata[23:16]) * W_RED
				+ 15'(s_axis_tdata[15:8]) * W_GREEN
				+ 15'(s_axis_tdata[7:0]) * W_BLUE;
			px_s2    <= px_s1;
			gray_s2  <= gprod[GRAY_SHIFT +: 8];
			px_s3    <= px_s2;
			gray_s3  <= gray_s2;
			dist_s3  <= sq_dist;
			px_s4    <= px_s3;
			dark_s4  <= (gray_s3 < DARK_LIMIT) && (dist_s3 < NEUTRAL_LIMIT);
			light_s4 <= (gray_s3 > LIGHT_LIMIT) && (dist_s3 < NEUTRAL_LIMIT);
			px_s5    <= px_next;
		end
	end

	pcmt_ramp u_ramp_r (
		.clk(clk), .en(en), .gray_s2(gray_s2),
		.fc(fore_q[7:0]), .bc(back_q[7:0]), .ramp(ramp_r)
	);
	pcmt_ramp u_ramp_g (
		.clk(clk), .en(en), .gray_s2(gray_s2),
		.fc(fore_q[15:8]), .bc(back_q[15:8]), .ramp(ramp_g)
	);
	pcmt_ramp u_ramp_b (
		.clk(clk), .en(en), .gray_s2(gray_s2),
		.fc(fore_q[23:16]), .bc(back_q[23:16]), .ramp(ramp_b)
	);

	always_comb begin
		px_next = px_s4;
		unique case (mode_q)
			MODE_NORMAL, MODE_ALPHA: px_next = px_s4;
			MODE_TWOCOLOR: begin
				if (dark_s4)
					px_next = {px_s4[31:24], fore_q[7:0], fore_q[15:8], fore_q[23:16]};
				else if (light_s4)
					px_next = {px_s4[31:24], back_q[7:0], back_q[15:8], back_q[23:16]};
				else
					px_next = px_s4;
			end
			MODE_RAMP: px_next = {px_s4[31:24], ramp_r, ramp_g, ramp_b};
			default:   px_next = px_s4;
		endcase
	end

	assign m_axis_tvalid = vld_s5;
	assign m_axis_tdata  = px_s5;

`ifndef SYNTHESIS
	a_rise_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(vld_s4))
		else $error("output valid without an item in s4");

	a_alpha_kept: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s4 |=> m_axis_tdata[31:24] == $past(px_s4[31:24]))
		else $error("alpha changed");

	a_pass_modes: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s4 && (mode_q == MODE_NORMAL || mode_q == MODE_ALPHA)
		|=> m_axis_tdata == $past(px_s4))
		else $error("pass-through mode altered pixel");

	a_wsum_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ws_s1 <= WSUM_MAX)
		else $error("luma sum out of range");
`endif

endmodule
